/* sv/dictionary_longest_prefix_match_macros.svh */
// Assertion helpers for the dictionary block.
`ifndef DICTIONARY_LONGEST_PREFIX_MATCH_MACROS_SVH
`define DICTIONARY_LONGEST_PREFIX_MATCH_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DLPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define DLPM_ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) else $error(msg);

`endif

/* sv/dlpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dlpm_pkg;

  localparam int MAX_WORD_LEN     = 20;
  localparam int MAX_LOADED_WORDS = 414;
  localparam int TABLE_WORDS      = 512;
  localparam int BASE_WORDS       = 98;
  localparam int CHAR_W           = 7;
  localparam int CODE_W           = 9;
  localparam int STATUS_W         = 3;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_INVALID = 3'd1,
    STAT_BADLEN  = 3'd2,
    STAT_DUP     = 3'd3,
    STAT_FULL    = 3'd4,
    STAT_NOMATCH = 3'd5
  } status_t;

  // Result of comparing one stored word with the collected item.
  typedef struct packed {
    logic lt;
    logic eq;
    logic pfx;
  } cmp_res_t;

  // Tab, LF, CR and the printable range.
  function automatic logic valid_char(input logic [7:0] c);
    return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || ((c >= 8'h20) && (c <= 8'h7E));
  endfunction

  // Character of the k-th single-character base word in sorted order.
  function automatic logic [CHAR_W-1:0] base_char(input logic [CHAR_W-1:0] k);
    logic [CHAR_W-1:0] c;
    if (k == 7'd0) begin
      c = 7'h09;
    end else if (k == 7'd1) begin
      c = 7'h0A;
    end else if (k == 7'd2) begin
      c = 7'h0D;
    end else begin
      c = k - 7'd3 + 7'h20;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/dlpm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Request channel carrying one character per item.
interface dlpm_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, func, ch, last, input ready);
  modport sink (input valid, func, ch, last, output ready);
endinterface

// Result channel.
interface dlpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [dlpm_pkg::CODE_W-1:0]   code;
  logic [dlpm_pkg::STATUS_W-1:0] status;
  logic                          was_query;
  modport source (output valid, code, status, was_query, input ready);
  modport sink (input valid, code, status, was_query, output ready);
endinterface
`default_nettype wire

/* sv/dlpm_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// Word table: one write port, one read port, registered read data.
module dlpm_mem #(
  parameter int DEPTH = dlpm_pkg::TABLE_WORDS,
  parameter int WIDTH = 145
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/dlpm_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none
// Compares one stored word with the first n characters of the item.
module dlpm_cmp #(
  parameter int MAX_WORD_LEN = dlpm_pkg::MAX_WORD_LEN,
  localparam int WLEN_W = $clog2(MAX_WORD_LEN + 1),
  localparam int ROW_W  = MAX_WORD_LEN * dlpm_pkg::CHAR_W + WLEN_W
) (
  input  wire logic [ROW_W-1:0]          row,
  input  wire logic [MAX_WORD_LEN*8-1:0] item,
  input  wire logic [WLEN_W-1:0]         n,
  output dlpm_pkg::cmp_res_t             res
);

  localparam int CW = dlpm_pkg::CHAR_W;

  logic [WLEN_W-1:0] len;
  logic [WLEN_W-1:0] m;
  logic              found;
  logic              lt_c;
  logic [7:0]        rc;
  logic [7:0]        bc;

  assign len = row[MAX_WORD_LEN*CW +: WLEN_W];
  assign m   = (len < n) ? len : n;

  // First mismatching position decides the order.
  always_comb begin
    found = 1'b0;
    lt_c  = 1'b0;
    rc    = '0;
    bc    = '0;
    for (int k = MAX_WORD_LEN - 1; k >= 0; k--) begin
      rc = {1'b0, row[k*CW +: CW]};
      bc = item[k*8 +: 8];
      if ((k < int'(m)) && (rc != bc)) begin
        found = 1'b1;
        lt_c  = rc < bc;
      end
    end
  end

  always_comb begin
    res.lt  = found ? lt_c : (len < n);
    res.eq  = !found && (len == n);
    res.pfx = !found && (len != '0) && (len <= n);
  end

endmodule
`default_nettype wire

/* sv/dictionary_longest_prefix_match.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sorted dictionary with longest-prefix lookup. Character items that are not
// the last of their word or query are taken while the block is idle. A final
// item starts a linear scan over the word table, one stored word per cycle
// through the single read port. A load follows the search by moving every
// word at or above the sorted position up one row and then writing the new
// word there. A duplicate ends the search early. Loads that fail the full,
// length or character check skip the scan. After reset a loading pass
// writes the 98 single-character words; no request is taken during it. A
// finished result waits in an output register while the next characters
// are collected.
module dictionary_longest_prefix_match #(
  parameter int MAX_WORD_LEN     = dlpm_pkg::MAX_WORD_LEN,
  parameter int MAX_LOADED_WORDS = dlpm_pkg::MAX_LOADED_WORDS,
  parameter int TABLE_WORDS      = dlpm_pkg::TABLE_WORDS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dlpm_in_if.sink   in_req,
  dlpm_out_if.source out_res
);

  localparam int CW     = dlpm_pkg::CHAR_W;
  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 2);
  localparam int WLEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int BI_W   = $clog2(MAX_WORD_LEN);
  localparam int IDX_W  = $clog2(TABLE_WORDS);
  localparam int CNT_W  = $clog2(TABLE_WORDS + 1);
  localparam int ROW_W  = MAX_WORD_LEN * CW + WLEN_W;
  localparam int LIMIT  = dlpm_pkg::BASE_WORDS + MAX_LOADED_WORDS;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_START = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                  state_r;
  logic [CW-1:0]           init_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [7:0]              buf_r [MAX_WORD_LEN];
  logic [LEN_W-1:0]        len_r;
  logic                    bad_r;
  logic                    func_r;
  logic [CNT_W-1:0]        scan_r;
  logic                    rdv_r;
  logic [IDX_W-1:0]        rdi_r;
  logic [CNT_W-1:0]        pos_r;
  logic [WLEN_W-1:0]       best_r;
  logic [IDX_W-1:0]        code_r;
  dlpm_pkg::status_t       st_r;
  logic                    ovalid_r;
  logic [dlpm_pkg::CODE_W-1:0] ocode_r;
  dlpm_pkg::status_t       ostat_r;
  logic                    oquery_r;

  logic                      in_acc;
  logic                      issue;
  logic [WLEN_W-1:0]         n;
  logic [MAX_WORD_LEN*8-1:0] item_flat;
  logic [ROW_W-1:0]          rdata;
  logic [ROW_W-1:0]          new_row;
  logic [ROW_W-1:0]          init_row;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [ROW_W-1:0]          wdata;
  logic [IDX_W-1:0]          raddr;
  dlpm_pkg::cmp_res_t        cres;
  logic [WLEN_W-1:0]         row_len;
  logic                      out_free;

  assign in_acc   = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign out_free = !ovalid_r || out_res.ready;
  assign n        = (len_r > LEN_W'(MAX_WORD_LEN)) ? WLEN_W'(MAX_WORD_LEN) : WLEN_W'(len_r);
  assign row_len  = rdata[MAX_WORD_LEN*CW +: WLEN_W];

  // Flattened item, the row written for a new word and the base-word row.
  always_comb begin
    item_flat = '0;
    new_row   = '0;
    init_row  = '0;
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      item_flat[k*8 +: 8] = buf_r[k];
      if (k < int'(n)) begin
        new_row[k*CW +: CW] = buf_r[k][CW-1:0];
      end
    end
    new_row[MAX_WORD_LEN*CW +: WLEN_W]  = n;
    init_row[0 +: CW]                   = dlpm_pkg::base_char(init_r);
    init_row[MAX_WORD_LEN*CW +: WLEN_W] = WLEN_W'(1);
  end

  // Read issue for the scan (ascending) and the shift (descending).
  always_comb begin
    issue = 1'b0;
    raddr = scan_r[IDX_W-1:0];
    if (state_r == S_SCAN) begin
      issue = scan_r < cnt_r;
    end else if (state_r == S_SHIFT) begin
      issue = scan_r > pos_r;
      raddr = IDX_W'(scan_r - CNT_W'(1));
    end
  end

  // Write port: base words, moved words, the new word.
  always_comb begin
    we    = 1'b0;
    waddr = rdi_r + IDX_W'(1);
    wdata = rdata;
    priority case (1'b1)
      state_r == S_INIT: begin
        we    = 1'b1;
        waddr = IDX_W'(init_r);
        wdata = init_row;
      end
      state_r == S_SHIFT: begin
        we = rdv_r;
      end
      state_r == S_WRITE: begin
        we    = 1'b1;
        waddr = pos_r[IDX_W-1:0];
        wdata = new_row;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  dlpm_mem #(.DEPTH(TABLE_WORDS), .WIDTH(ROW_W)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  dlpm_cmp #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_cmp (
    .row  (rdata),
    .item (item_flat),
    .n    (n),
    .res  (cres)
  );

  // Character buffer collects bytes of the current word or query.
  always_ff @(posedge clk) begin
    if (in_acc && (len_r < LEN_W'(MAX_WORD_LEN))) begin
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
        if (len_r[BI_W-1:0] == BI_W'(k)) begin
          buf_r[k] <= in_req.ch;
        end
      end
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      init_r   <= '0;
      cnt_r    <= CNT_W'(dlpm_pkg::BASE_WORDS);
      len_r    <= '0;
      bad_r    <= 1'b0;
      rdv_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      rdv_r <= issue;
      rdi_r <= raddr;
      if (issue) begin
        scan_r <= (state_r == S_SHIFT) ? scan_r - CNT_W'(1) : scan_r + CNT_W'(1);
      end
      // A result loaded in the finish state replaces the one leaving.
      if (ovalid_r && out_res.ready && (state_r != S_FIN)) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          init_r <= init_r + CW'(1);
          if (init_r == CW'(dlpm_pkg::BASE_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (len_r < LEN_W'(MAX_WORD_LEN)) begin
              len_r <= len_r + LEN_W'(1);
            end else begin
              len_r <= LEN_W'(MAX_WORD_LEN + 1);
            end
            if (!dlpm_pkg::valid_char(in_req.ch)) begin
              bad_r <= 1'b1;
            end
            func_r <= in_req.func;
            if (in_req.last) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          scan_r <= '0;
          pos_r  <= '0;
          best_r <= '0;
          code_r <= '0;
          if (func_r) begin
            state_r <= S_SCAN;
          end else if ((int'(cnt_r) >= LIMIT) || (int'(cnt_r) >= TABLE_WORDS)) begin
            st_r    <= dlpm_pkg::STAT_FULL;
            state_r <= S_FIN;
          end else if ((len_r < LEN_W'(2)) || (len_r > LEN_W'(MAX_WORD_LEN))) begin
            st_r    <= dlpm_pkg::STAT_BADLEN;
            state_r <= S_FIN;
          end else if (bad_r) begin
            st_r    <= dlpm_pkg::STAT_INVALID;
            state_r <= S_FIN;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rdv_r && !func_r && cres.eq) begin
            st_r    <= dlpm_pkg::STAT_DUP;
            state_r <= S_FIN;
          end else begin
            if (rdv_r && !func_r && cres.lt) begin
              pos_r <= pos_r + CNT_W'(1);
            end
            if (rdv_r && func_r && cres.pfx && (row_len > best_r)) begin
              best_r <= row_len;
              code_r <= rdi_r;
            end
            if (!rdv_r && !issue) begin
              if (func_r) begin
                st_r    <= (best_r != '0) ? dlpm_pkg::STAT_OK : dlpm_pkg::STAT_NOMATCH;
                state_r <= S_FIN;
              end else begin
                scan_r  <= cnt_r;
                state_r <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          if (!rdv_r && !issue) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          cnt_r   <= cnt_r + CNT_W'(1);
          st_r    <= dlpm_pkg::STAT_OK;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            ovalid_r <= 1'b1;
            ocode_r  <= dlpm_pkg::CODE_W'(code_r);
            ostat_r  <= st_r;
            oquery_r <= func_r;
            len_r    <= '0;
            bad_r    <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid     = ovalid_r;
  assign out_res.code      = ocode_r;
  assign out_res.status    = ostat_r;
  assign out_res.was_query = oquery_r;

  `include "dictionary_longest_prefix_match_macros.svh"

  // The table never holds more words than it has rows.
  `DLPM_ASSERT(a_cnt_bound, clk, rst_n, int'(cnt_r) <= TABLE_WORDS, "entry count overflow")
  // An insert grows the table by exactly one word.
  `DLPM_ASSERT_NEXT(a_cnt_inc, clk, rst_n, state_r == S_WRITE, cnt_r == $past(cnt_r) + CNT_W'(1), "insert count slip")
  // Moving words never runs below the insert position.
  `DLPM_ASSERT(a_shift_pos, clk, rst_n, (state_r != S_SHIFT) || (scan_r >= pos_r), "shift passed insert position")
  // The table only grows through the insert step.
  `DLPM_ASSERT_NEXT(a_cnt_hold, clk, rst_n, state_r != S_WRITE, $stable(cnt_r), "count changed outside insert")

endmodule
`default_nettype wire

/* sim/dictionary_longest_prefix_match_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Watches both channels, keeps its own copy of the dictionary and compares
// every result with the oldest predicted one.
module dictionary_longest_prefix_match_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  dlpm_in_if       in_mon,
  dlpm_out_if      out_mon,
  output int       fail_count,
  output int       pending_count,
  output int       loaded_count
);
  import dlpm_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    status_t           status;
    logic              was_query;
  } lookup_res_t;

  logic [7:0]  dict_chars [TABLE_WORDS][MAX_WORD_LEN];
  int          dict_len [TABLE_WORDS];
  int          dict_count;
  logic [7:0]  pend_chars [MAX_WORD_LEN];
  int          pend_len;
  logic        pend_bad;
  lookup_res_t expected_q[$];

  assign pending_count = expected_q.size();
  assign loaded_count  = dict_count - BASE_WORDS;

  function automatic logic char_ok(input logic [7:0] c);
    return c == 8'h09 || c == 8'h0A || c == 8'h0D || (c >= 8'h20 && c <= 8'h7E);
  endfunction

  // Orders stored word e against the first n collected characters.
  function automatic int compare_word(input int e, input int n);
    int m;
    m = dict_len[e] < n ? dict_len[e] : n;
    for (int k = 0; k < m; k++)
      if (dict_chars[e][k] != pend_chars[k]) return dict_chars[e][k] < pend_chars[k] ? -1 : 1;
    if (dict_len[e] == n) return 0;
    return dict_len[e] < n ? -1 : 1;
  endfunction

  function automatic status_t insert_word();
    int pos;
    int c;
    pos = 0;
    if (dict_count >= BASE_WORDS + MAX_LOADED_WORDS || dict_count >= TABLE_WORDS)
      return STAT_FULL;
    if (pend_len < 2 || pend_len > MAX_WORD_LEN) return STAT_BADLEN;
    if (pend_bad) return STAT_INVALID;
    for (int e = 0; e < dict_count; e++) begin
      c = compare_word(e, pend_len);
      if (c == 0) return STAT_DUP;
      if (c < 0) pos++;
    end
    for (int e = dict_count; e > pos; e--) begin
      dict_chars[e] = dict_chars[e-1];
      dict_len[e] = dict_len[e-1];
    end
    for (int k = 0; k < MAX_WORD_LEN; k++) dict_chars[pos][k] = k < pend_len ? pend_chars[k] : 8'h00;
    dict_len[pos] = pend_len;
    dict_count++;
    return STAT_OK;
  endfunction

  // Folds one request into the collected item and predicts its result.
  function automatic void take_char(input logic func, input logic [7:0] ch, input logic last);
    lookup_res_t r;
    int n;
    int best;
    logic hit;
    if (pend_len < MAX_WORD_LEN) begin
      pend_chars[pend_len] = ch;
      pend_len++;
    end else begin
      pend_len = MAX_WORD_LEN + 1;
    end
    if (!char_ok(ch)) pend_bad = 1'b1;
    if (!last) return;
    r.code = '0;
    r.was_query = func;
    if (!func) begin
      r.status = insert_word();
    end else begin
      n = pend_len > MAX_WORD_LEN ? MAX_WORD_LEN : pend_len;
      best = 0;
      for (int e = 0; e < dict_count; e++) begin
        if (dict_len[e] > best && dict_len[e] <= n) begin
          hit = 1'b1;
          for (int k = 0; k < dict_len[e]; k++)
            if (dict_chars[e][k] != pend_chars[k]) hit = 1'b0;
          if (hit) begin
            best = dict_len[e];
            r.code = e[CODE_W-1:0];
          end
        end
      end
      r.status = best != 0 ? STAT_OK : STAT_NOMATCH;
    end
    pend_len = 0;
    pend_bad = 1'b0;
    expected_q.push_back(r);
  endfunction

  // Compares each accepted result with the oldest prediction and folds in each accepted request.
  always @(posedge clk) begin
    lookup_res_t want;
    int k;
    if (!rst_n) begin
      k = 0;
      for (int e = 0; e < TABLE_WORDS; e++) begin
        dict_len[e] = 0;
        for (int j = 0; j < MAX_WORD_LEN; j++) dict_chars[e][j] = 8'h00;
      end
      for (int c = 0; c < 127; c++)
        if (char_ok(c[7:0])) begin
          dict_chars[k][0] = c[7:0];
          dict_len[k] = 1;
          k++;
        end
      dict_count = k;
      pend_len = 0;
      pend_bad = 1'b0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result code=%0d status=%0d was_query=%0b",
                     out_mon.code, out_mon.status, out_mon.was_query);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.code !== out_mon.code || want.status !== out_mon.status ||
              want.was_query !== out_mon.was_query) begin
            if (fail_count < 10)
              $display("mismatch: expected code=%0d status=%0d was_query=%0b, got %0d %0d %0b",
                       want.code, want.status, want.was_query,
                       out_mon.code, out_mon.status, out_mon.was_query);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) take_char(in_mon.func, in_mon.ch, in_mon.last);
    end
  end
endmodule
`default_nettype wire

/* sim/dictionary_longest_prefix_match_test.sv */
`timescale 1ns / 1ps
`default_nettype none
// Drives character requests into the dictionary, with random gaps on both
// sides, and reports the verdict from the checker's failure and pending counts.
module dictionary_longest_prefix_match_test;
  import dlpm_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   loaded_count;
  int   idle_cycles;
  bit   hold_sink;
  bit   stim_done;
  logic [7:0] word_bank [64][MAX_WORD_LEN];
  int   word_bank_len [64];
  int   bank_size;

  dlpm_in_if  in_req ();
  dlpm_out_if out_res ();

  dictionary_longest_prefix_match dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_res(out_res.source)
  );

  dictionary_longest_prefix_match_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_req), .out_mon(out_res),
    .fail_count(fail_count), .pending_count(pending_count), .loaded_count(loaded_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Sends one character request and waits until it is taken. The request
  // stays offered into the next call when that one has no gap.
  task automatic send_char(input logic func, input logic [7:0] ch, input logic last);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.func  <= func;
    in_req.ch    <= ch;
    in_req.last  <= last;
    do @(posedge clk); while (!in_req.ready);
  endtask

  function automatic logic [7:0] good_char();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return 8'h09;
    if (r == 1) return 8'h0A;
    if (r == 2) return 8'h0D;
    if (r < 60) return 8'h61 + 8'($urandom_range(0, 5));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Sends a word or query of n characters taken from chars.
  task automatic send_string(input logic func, input logic [7:0] chars [MAX_WORD_LEN + 4],
                             input int n);
    for (int k = 0; k < n; k++) send_char(func, chars[k], k == n - 1);
  endtask

  task automatic send_random_item(input logic func, input bit noisy);
    logic [7:0] chars [MAX_WORD_LEN + 4];
    int n;
    int b;
    n = noisy ? $urandom_range(1, MAX_WORD_LEN + 4) : $urandom_range(1, 8);
    if (func && bank_size > 0 && $urandom_range(0, 2) != 0) begin
      b = $urandom_range(0, bank_size - 1);
      for (int k = 0; k < word_bank_len[b]; k++) chars[k] = word_bank[b][k];
      for (int k = word_bank_len[b]; k < MAX_WORD_LEN + 4; k++) chars[k] = good_char();
      n = word_bank_len[b] + $urandom_range(0, 3);
    end else begin
      for (int k = 0; k < MAX_WORD_LEN + 4; k++)
        chars[k] = noisy && $urandom_range(0, 4) == 0 ? 8'($urandom) : good_char();
    end
    if (!func && n >= 2 && n <= MAX_WORD_LEN && bank_size < 64) begin
      for (int k = 0; k < n; k++) word_bank[bank_size][k] = chars[k];
      word_bank_len[bank_size] = n;
      bank_size++;
    end
    // Characters before the last carry a random function; the final one carries func.
    for (int k = 0; k < n; k++)
      send_char(k == n - 1 ? func : logic'($urandom_range(0, 1)), chars[k], k == n - 1);
  endtask

  // Withdraws the request and waits until every predicted result has come.
  task automatic wait_drained();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Result side: random stalls, or a long hold-off when requested.
  initial begin
    out_res.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_res.ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_sink = 1'b0;
      end
      out_res.ready <= ($urandom_range(0, 3) != 0) || stim_done;
      @(posedge clk);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("dictionary_longest_prefix_match_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] s [MAX_WORD_LEN + 4];
    int sent;
    bank_size = 0;
    hold_sink = 1'b0;
    stim_done = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.func = 1'b0;
    in_req.ch = 8'h00;
    in_req.last = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: single-character queries at the extremes, a load and
    // its duplicate, bad length, invalid character, and an overlong query.
    send_char(1'b1, 8'h09, 1'b1);
    send_char(1'b1, 8'h7E, 1'b1);
    send_char(1'b1, 8'h00, 1'b1);
    send_char(1'b1, 8'hFF, 1'b1);
    send_char(1'b0, 8'h41, 1'b1);
    s[0] = 8'h61; s[1] = 8'h62;
    send_string(1'b0, s, 2);
    send_string(1'b0, s, 2);
    send_string(1'b1, s, 2);
    s[2] = 8'h80;
    send_string(1'b0, s, 3);
    send_string(1'b1, s, 3);
    for (int k = 0; k < MAX_WORD_LEN + 2; k++) s[k] = 8'h61 + 8'(k % 3);
    send_string(1'b0, s, MAX_WORD_LEN);
    send_string(1'b0, s, MAX_WORD_LEN + 2);
    send_string(1'b1, s, MAX_WORD_LEN + 2);
    wait_drained();

    // Random part, with one long result stall and one full drain.
    sent = 0;
    while (sent < 320) begin
      if (sent == 160) hold_sink = 1'b1;
      if (sent == 240) wait_drained();
      send_random_item(logic'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
      sent += 8;
    end

    // Fill the table up to its load limit with random two-character words, then try one more load.
    while (loaded_count < MAX_LOADED_WORDS) begin
      for (int k = 0; k < 2; k++) s[k] = 8'($urandom_range(8'h21, 8'h7E));
      send_string(1'b0, s, 2);
      wait_drained();
    end
    send_string(1'b0, s, 3);
    send_string(1'b1, s, 6);
    for (int i = 0; i < 10; i++) send_random_item(1'b1, 1'b0);

    stim_done = 1'b1;
    wait_drained();
    repeat (600) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("dictionary_longest_prefix_match_test: PASS");
    end else begin
      $display("dictionary_longest_prefix_match_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
